### hdl/optional_wildcard_pattern_scan_unit_assert.svh
// Assertion macros used by the pattern scan unit RTL.
`ifndef OPTIONAL_WILDCARD_PATTERN_SCAN_UNIT_ASSERT_SVH
`define OPTIONAL_WILDCARD_PATTERN_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OWPS_ASSERT_IMPLIES(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OWPS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/owps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owps_pkg;

    // Fixed field widths.
    localparam int BYTE_W        = 8;
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_BITS  = PATTERN_BYTES * BYTE_W;
    localparam int ADDR_W        = 32;
    localparam int OFFSET_W      = 16;
    localparam int LEN_REG_W     = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Default window depth.
    localparam int MAX_PATTERN_DEFAULT = 16;

    // A pattern byte of this value matches anything in wildcard mode.
    localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW     = 3'd0,
        REG_PATTERN_HIGH    = 3'd1,
        REG_PATTERN_LENGTH  = 3'd2,
        REG_WILDCARD_ENABLE = 3'd3,
        REG_RESULT_OFFSET   = 3'd4,
        REG_REGION_START    = 3'd5,
        REG_REGION_END      = 3'd6
    } cfg_reg_t;

    // Compare settings broadcast to every cell of the window.
    typedef struct packed {
        logic                    wildcard_enable;
        logic [PATTERN_BITS-1:0] pattern;
    } match_cfg_t;

endpackage

`default_nettype wire

### hdl/optional_wildcard_pattern_scan_unit.sv
// Streaming wildcard byte-pattern search. Memory bytes enter one per transfer in
// address order; a byte with restart set lies at region_start and opens a new scan.
// The byte window is a row of cells that shift on every byte taken in an open scan
// and compare their entry against the pattern in parallel, so one byte is taken every
// clock cycle and the outcome of a byte is decided in the cycle it is taken. A result
// (found with match address, or not found with address 0) appears on the output
// register in the cycle after the byte that caused it, and at most one result comes
// per scan; bytes after that are ignored until the next restart. The input stalls
// only while a result waits in the output register and m_ready is low.
// Configuration writes are taken every cycle and must happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "optional_wildcard_pattern_scan_unit_assert.svh"

module optional_wildcard_pattern_scan_unit #(
    parameter int MAX_PATTERN = owps_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [owps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owps_pkg::CFG_DATA_W-1:0] cfg_data,
    // Byte input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [owps_pkg::BYTE_W-1:0]   s_mem_byte,
    input  wire logic                          s_restart,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic      [owps_pkg::ADDR_W-1:0]   m_match_address
);
    import owps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [PATTERN_BITS-1:0] pattern_reg;
    logic [LEN_REG_W-1:0]    pattern_length_reg;
    logic                    wildcard_enable_reg;
    logic [OFFSET_W-1:0]     result_offset_reg;
    logic [ADDR_W-1:0]       region_start_reg;
    logic [ADDR_W-1:0]       region_end_reg;

    // Scan state
    logic              scan_done_reg;
    logic              scan_done_next;
    logic [ADDR_W-1:0] scan_address_reg;
    logic [ADDR_W-1:0] scan_address_next;
    logic [LEN_W-1:0]  fill_count_reg;
    logic [LEN_W-1:0]  fill_count_next;

    // Output register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_found_reg;
    logic [ADDR_W-1:0] m_match_address_reg;

    logic              take;
    logic              active;
    logic              emit;
    logic              load_result;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  lag;
    logic              window_full;
    logic              bound_ok;
    logic              hit;
    logic              exhausted;
    logic [ADDR_W-1:0] cand;
    logic [ADDR_W-1:0] next_cand;
    logic [ADDR_W-1:0] offset_ext;
    logic [ADDR_W-1:0] result_address;

    logic [BYTE_W-1:0]  chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_match;
    match_cfg_t         mcfg;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg         <= '0;
            pattern_length_reg  <= LEN_REG_W'(1);
            wildcard_enable_reg <= 1'b0;
            result_offset_reg   <= '0;
            region_start_reg    <= '0;
            region_end_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:     pattern_reg[PATTERN_BITS/2-1:0] <= cfg_data;
                REG_PATTERN_HIGH:    pattern_reg[PATTERN_BITS-1:PATTERN_BITS/2] <= cfg_data;
                REG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_data[LEN_REG_W-1:0];
                REG_WILDCARD_ENABLE: wildcard_enable_reg <= cfg_data[0];
                REG_RESULT_OFFSET:   result_offset_reg   <= cfg_data[OFFSET_W-1:0];
                REG_REGION_START:    region_start_reg    <= cfg_data[ADDR_W-1:0];
                REG_REGION_END:      region_end_reg      <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length, clamped to one and to the window depth.
    always_comb begin
        if (pattern_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (int'(pattern_length_reg) > MAX_PATTERN) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = LEN_W'(pattern_length_reg);
        end
    end

    assign len_m1 = len - LEN_W'(1);

    // Handshake: a byte is taken while the output register can take a result.
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign active  = s_restart || !scan_done_reg;

    // Address and fill count after this byte.
    always_comb begin
        if (s_restart) begin
            scan_address_next = region_start_reg;
            fill_count_next   = LEN_W'(1);
        end else begin
            scan_address_next = scan_address_reg + ADDR_W'(1);
            fill_count_next   = (fill_count_reg == LEN_W'(MAX_PATTERN))
                                ? fill_count_reg : fill_count_reg + LEN_W'(1);
        end
    end

    // Window row: cell k holds the byte k places behind the newest one.
    assign mcfg.wildcard_enable = wildcard_enable_reg;
    assign mcfg.pattern         = pattern_reg;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        owps_cell #(
            .IDX   (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (take && active),
            .byte_in  ((k == 0) ? s_mem_byte : chain[(k == 0) ? 0 : k-1]),
            .len      (len),
            .mcfg     (mcfg),
            .byte_out (chain[k]),
            .match    (cell_match[k])
        );
    end

    // Candidate test: oldest byte of a full window, bounded without wrap.
    assign window_full = (fill_count_next >= len);
    assign cand        = scan_address_next - ADDR_W'(len_m1);
    assign bound_ok    = ({1'b0, cand} + (ADDR_W+1)'(len)) < {1'b0, region_end_reg};
    assign hit         = window_full && bound_ok && (&cell_match);

    // Exhaustion test on the earliest candidate still undecided.
    assign lag       = (fill_count_next < len_m1) ? fill_count_next : len_m1;
    assign next_cand = scan_address_next - ADDR_W'(lag) + ADDR_W'(1);
    assign exhausted = ({1'b0, next_cand} + (ADDR_W+1)'(len)) >= {1'b0, region_end_reg};

    assign emit        = hit || exhausted;
    assign load_result = take && active && emit;

    assign offset_ext     = {{(ADDR_W-OFFSET_W){result_offset_reg[OFFSET_W-1]}},
                             result_offset_reg};
    assign result_address = hit ? (cand + offset_ext) : '0;

    // A scan ends with its single result.
    assign scan_done_next = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_done_reg    <= 1'b1;
            scan_address_reg <= '0;
            fill_count_reg   <= '0;
        end else if (take && active) begin
            scan_done_reg    <= scan_done_next;
            scan_address_reg <= scan_address_next;
            fill_count_reg   <= fill_count_next;
        end
    end

    // Result register; holds its transfer until m_ready.
    assign m_valid_next = load_result || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_found_reg         <= hit;
            m_match_address_reg <= result_address;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_match_address_reg;

    // Checks on the scan control.
    `OWPS_ASSERT_NEXT(a_done_after_result, aclk, aresetn, load_result, scan_done_reg, "scan still open after its result")
    `OWPS_ASSERT_NEXT(a_idle_ignores_bytes, aclk, aresetn, take && !s_restart && scan_done_reg, scan_done_reg && $stable(scan_address_reg), "idle scan reacted to a byte")
    `OWPS_ASSERT_NEXT(a_restart_fill, aclk, aresetn, take && s_restart, fill_count_reg == LEN_W'(1), "restart did not reopen the window")
    `OWPS_ASSERT_IMPLIES(a_not_found_zero, aclk, aresetn, m_valid_reg && !m_found_reg, m_match_address_reg == '0, "not-found result carries an address")

endmodule

`default_nettype wire

### hdl/owps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module owps_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic [owps_pkg::BYTE_W-1:0] byte_in,
    input  wire logic [LEN_W-1:0]           len,
    input  wire owps_pkg::match_cfg_t       mcfg,
    output logic      [owps_pkg::BYTE_W-1:0] byte_out,
    output logic                            match
);
    import owps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  pat_idx;
    logic [7:0]        pat_idx_wide;
    logic [BYTE_W-1:0] pat_byte;
    logic [BYTE_W-1:0] pat_bytes [PATTERN_BYTES];
    logic              in_use;

    // Window byte, handed to the next cell on every shift.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Split the pattern into bytes.
    always_comb begin
        for (int b = 0; b < PATTERN_BYTES; b++) begin
            pat_bytes[b] = mcfg.pattern[b*BYTE_W +: BYTE_W];
        end
    end

    // This cell holds window entry IDX, which lines up with pattern byte len-1-IDX.
    assign in_use       = (IDX < int'(len));
    assign pat_idx      = LEN_W'(len - LEN_W'(1) - LEN_W'(IDX));
    assign pat_idx_wide = 8'(pat_idx);
    assign pat_byte     = (pat_idx_wide < 8'(PATTERN_BYTES)) ? pat_bytes[pat_idx_wide[3:0]]
                                                             : '0;

    // Compare the byte entering this entry; unused entries never block a match.
    assign match = !in_use || (byte_in == pat_byte) ||
                   (mcfg.wildcard_enable && (pat_byte == WILDCARD_BYTE));

endmodule

`default_nettype wire
